// ----- sv/lsrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lsrs_pkg
// Shared widths, register indexes, reset values and result flag type of the
// line sensor readout sequencer.
// ----------------------------------------------------------------------------
package lsrs_pkg;

    // sequence counter and configuration widths
    localparam int CNT_W      = 24;
    localparam int CORR_W     = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTEG_CLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTEG_CORR   = 2'd1;

    // configuration reset values
    localparam logic [CNT_W-1:0]  INTEG_CLOCKS_RST = 24'd50000;
    localparam logic [CORR_W-1:0] INTEG_CORR_RST   = 8'd48;

    // fixed clock counts of the sequence
    localparam logic [CNT_W-1:0] PRE_CLOCKS  = 24'd3;
    localparam logic [CNT_W-1:0] POST_CLOCKS = 24'(48 + 40);

    // parameter defaults
    localparam int NUM_CHANNELS_DEF = 288;
    localparam int SAMPLE_BITS_DEF  = 12;

    // per-request result flags
    typedef struct packed {
        logic clock_level;
        logic start_level;
        logic pixel_valid;
        logic pixel_last;
        logic busy;
    } t_flags;

endpackage

// ----- sv/lsrs_cfg.sv -----
// ----------------------------------------------------------------------------
// lsrs_cfg
// Configuration registers and the corrected integration length, floored at
// zero.
// ----------------------------------------------------------------------------
module lsrs_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lsrs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [lsrs_pkg::CNT_W-1:0]        o_integ_len
);
    import lsrs_pkg::*;

    logic [CNT_W-1:0]  r_integ_clocks;
    logic [CORR_W-1:0] r_integ_corr;
    logic [CNT_W-1:0]  corr_ext;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_clocks <= INTEG_CLOCKS_RST;
            r_integ_corr   <= INTEG_CORR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_INTEG_CLOCKS) begin
                r_integ_clocks <= i_cfg_data[CNT_W-1:0];
            end else if (i_cfg_index == CFG_IDX_INTEG_CORR) begin
                r_integ_corr <= i_cfg_data[CORR_W-1:0];
            end
        end
    end

    // corrected length, zero when the correction covers it
    assign corr_ext    = {{(CNT_W-CORR_W){1'b0}}, r_integ_corr};
    assign o_integ_len = (r_integ_clocks > corr_ext) ? (r_integ_clocks - corr_ext)
                                                     : '0;

endmodule

// ----- sv/lsrs_seq.sv -----
// ----------------------------------------------------------------------------
// lsrs_seq
// Sensor timing state machine: one half clock period per request, drives the
// clock and start levels and picks the channel samples.
// ----------------------------------------------------------------------------
module lsrs_seq #(
    parameter int NUM_CHANNELS = lsrs_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = lsrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_start_request,
    input  logic [SAMPLE_BITS-1:0]       i_video_sample,
    input  logic [lsrs_pkg::CNT_W-1:0]   i_integ_len,
    output lsrs_pkg::t_flags             o_flags,
    output logic [SAMPLE_BITS-1:0]       o_pixel_value
);
    import lsrs_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEAD  = 3'd1,
        PH_PRE   = 3'd2,
        PH_INTEG = 3'd3,
        PH_POST  = 3'd4,
        PH_READ  = 3'd5
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_half, n_half;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic             r_start, n_start;
    logic             r_clock, n_clock;
    logic [CNT_W-1:0] count_dec;
    t_flags           flags;
    logic [SAMPLE_BITS-1:0] value;

    // decremented clock count, held at zero
    assign count_dec = (r_count != '0) ? (r_count - 1'b1) : r_count;

    // next state and result of one half period
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_half  = r_half;
        n_ch    = r_ch;
        n_start = r_start;
        n_clock = r_clock;
        flags   = '0;
        value   = '0;
        flags.busy = 1'b1;
        case (r_phase)
            PH_LEAD: begin
                n_clock = 1'b0;
                n_start = 1'b1;
                n_phase = PH_PRE;
                n_count = PRE_CLOCKS;
                n_half  = 1'b0;
            end
            PH_PRE, PH_INTEG, PH_POST, PH_READ: begin
                if (!r_half) begin
                    // rising half, sample taken during readout
                    n_clock = 1'b1;
                    n_half  = 1'b1;
                    if (r_phase == PH_READ) begin
                        flags.pixel_valid = 1'b1;
                        flags.pixel_last  = (r_ch == LAST_CH);
                        value             = i_video_sample;
                    end
                end else begin
                    // falling half ends one full clock
                    n_clock = 1'b0;
                    n_half  = 1'b0;
                    if (r_phase == PH_READ) begin
                        if (r_ch == LAST_CH) begin
                            n_phase = PH_IDLE;
                            n_ch    = '0;
                        end else begin
                            n_ch = r_ch + 1'b1;
                        end
                    end else begin
                        n_count = count_dec;
                        if (count_dec == '0) begin
                            case (r_phase)
                                PH_PRE: begin
                                    if (i_integ_len == '0) begin
                                        n_phase = PH_POST;
                                        n_count = POST_CLOCKS;
                                        n_start = 1'b0;
                                    end else begin
                                        n_phase = PH_INTEG;
                                        n_count = i_integ_len;
                                    end
                                end
                                PH_INTEG: begin
                                    n_phase = PH_POST;
                                    n_count = POST_CLOCKS;
                                    n_start = 1'b0;
                                end
                                default: begin
                                    n_phase = PH_READ;
                                    n_ch    = '0;
                                end
                            endcase
                        end
                    end
                end
            end
            default: begin
                // idle and unused codes
                n_phase = PH_IDLE;
                n_start = 1'b0;
                if (i_start_request) begin
                    n_clock = 1'b1;
                    n_phase = PH_LEAD;
                    n_half  = 1'b1;
                end else begin
                    n_clock    = 1'b0;
                    flags.busy = 1'b0;
                end
            end
        endcase
        flags.clock_level = n_clock;
        flags.start_level = n_start;
    end

    // state registers, advanced once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_half  <= 1'b0;
            r_ch    <= '0;
            r_start <= 1'b0;
            r_clock <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_half  <= n_half;
            r_ch    <= n_ch;
            r_start <= n_start;
            r_clock <= n_clock;
        end
    end

    assign o_flags       = flags;
    assign o_pixel_value = value;

    // lead half always hands over to the pre clocks
    a_lead_to_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_phase == PH_LEAD |=> r_phase == PH_PRE && r_count == PRE_CLOCKS)
        else $error("lead half did not load pre clocks");

    // last channel clock ends the capture
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_phase == PH_READ && r_half && r_ch == LAST_CH |=> r_phase == PH_IDLE)
        else $error("capture did not end after last channel");

    // samples only appear with the clock driven high
    a_sample_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flags.pixel_valid |-> flags.clock_level && flags.busy)
        else $error("sample outside a rising clock half");

    // start line only high while a capture runs
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> r_phase != PH_IDLE)
        else $error("start line high while idle");

endmodule

// ----- sv/line_sensor_readout_sequencer.sv -----
// ----------------------------------------------------------------------------
// line_sensor_readout_sequencer
// Drives the clock and start lines of a line-scan sensor, one half clock period
// per request, and returns the captured video samples per channel.
// ----------------------------------------------------------------------------
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle unless stalled, set by the single state update
// per request. The output register is refilled in the cycle it drains, so stall only
// backs up when the result is held. Synchronous active-low reset returns the
// sequencer to idle with both sensor lines low and reloads the configuration.
module line_sensor_readout_sequencer #(
    parameter int NUM_CHANNELS = lsrs_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = lsrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [lsrs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsrs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_start_request,
    input  logic [SAMPLE_BITS-1:0]            i_video_sample,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_clock_level,
    output logic                              o_start_level,
    output logic                              o_pixel_valid,
    output logic [SAMPLE_BITS-1:0]            o_pixel_value,
    output logic                              o_pixel_last,
    output logic                              o_busy_res
);
    import lsrs_pkg::*;

    logic [CNT_W-1:0]       integ_len;
    logic                   in_accept;
    t_flags                 seq_flags;
    logic [SAMPLE_BITS-1:0] seq_value;
    logic                   r_out_valid;
    t_flags                 r_flags;
    logic [SAMPLE_BITS-1:0] r_value;

    // take a request whenever the output register is free or draining
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    lsrs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_integ_len (integ_len)
    );

    lsrs_seq #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (in_accept),
        .i_start_request (i_start_request),
        .i_video_sample  (i_video_sample),
        .i_integ_len     (integ_len),
        .o_flags         (seq_flags),
        .o_pixel_value   (seq_value)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_flags <= seq_flags;
            r_value <= seq_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_clock_level = r_flags.clock_level;
    assign o_start_level = r_flags.start_level;
    assign o_pixel_valid = r_flags.pixel_valid;
    assign o_pixel_value = r_value;
    assign o_pixel_last  = r_flags.pixel_last;
    assign o_busy_res    = r_flags.busy;

    // an accepted request always leaves a result waiting
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted request left no result");

    // a held result blocks new requests
    a_held_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !in_accept)
        else $error("request taken over a held result");

    // a result without a capture carries no pixel
    a_idle_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_flags.busy |-> !r_flags.pixel_valid && !r_flags.clock_level)
        else $error("idle result carries sensor activity");

endmodule

// ----- test/readout_check_pkg.sv -----
// ----------------------------------------------------------------------------
// readout_check_pkg
// Cycle-true prediction of the line sensor readout sequencer: one expected
// result per accepted request, kept in order and compared field by field.
// ----------------------------------------------------------------------------
package readout_check_pkg;

    import lsrs_pkg::*;

    localparam int NUM_CH = NUM_CHANNELS_DEF;
    localparam int SMP_W  = SAMPLE_BITS_DEF;

    // indexes past the end of the register map
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = 2'd3;

    // sequence phases
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LEAD,
        SEQ_PRE,
        SEQ_INTEG,
        SEQ_POST,
        SEQ_READ
    } seq_phase_e;

    typedef struct packed {
        t_flags            flags;
        logic [SMP_W-1:0]  pixel_value;
    } readout_result_t;

    class readout_scoreboard;

        // configuration copy
        logic [CNT_W-1:0]  integ_clocks;
        logic [CORR_W-1:0] integ_corr;

        // sequencer state
        seq_phase_e        phase;
        logic [CNT_W-1:0]  clocks_left;
        logic              low_half_next;
        logic [9:0]        channel;
        logic              start_line;
        logic              clock_line;

        readout_result_t   expected_q[$];
        int                mismatches;
        int                checked;
        int                captures;

        function new();
            integ_clocks  = INTEG_CLOCKS_RST;
            integ_corr    = INTEG_CORR_RST;
            phase         = SEQ_IDLE;
            clocks_left   = '0;
            low_half_next = 1'b0;
            channel       = '0;
            start_line    = 1'b0;
            clock_line    = 1'b0;
            mismatches    = 0;
            checked       = 0;
            captures      = 0;
        endfunction

        function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_INTEG_CLOCKS: integ_clocks = data[CNT_W-1:0];
                CFG_IDX_INTEG_CORR:   integ_corr   = data[CORR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit idle();
            return phase == SEQ_IDLE;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // integration length latched when the lead-in clocks end
        function void enter_integration();
            logic [CNT_W-1:0] span;
            span = (integ_clocks > CNT_W'(integ_corr)) ? integ_clocks - CNT_W'(integ_corr) : '0;
            if (span == '0) begin
                phase       = SEQ_POST;
                clocks_left = POST_CLOCKS;
                start_line  = 1'b0;
            end else begin
                phase       = SEQ_INTEG;
                clocks_left = span;
            end
        endfunction

        // end of one full sensor clock
        function void clock_finished();
            if (phase == SEQ_READ) begin
                channel = channel + 10'd1;
                if (channel >= NUM_CH) begin
                    phase   = SEQ_IDLE;
                    channel = '0;
                end
                return;
            end
            if (clocks_left != '0)
                clocks_left = clocks_left - 1'b1;
            if (clocks_left != '0)
                return;
            case (phase)
                SEQ_PRE: enter_integration();
                SEQ_INTEG: begin
                    phase       = SEQ_POST;
                    clocks_left = POST_CLOCKS;
                    start_line  = 1'b0;
                end
                default: begin
                    phase   = SEQ_READ;
                    channel = '0;
                end
            endcase
        endfunction

        // advance one half period and queue the result it produces
        function void note_request(logic req, logic [SMP_W-1:0] smp);
            readout_result_t exp_r;
            exp_r            = '0;
            exp_r.flags.busy = 1'b1;
            case (phase)
                SEQ_IDLE: begin
                    start_line = 1'b0;
                    if (req) begin
                        clock_line    = 1'b1;
                        phase         = SEQ_LEAD;
                        low_half_next = 1'b1;
                    end else begin
                        clock_line       = 1'b0;
                        exp_r.flags.busy = 1'b0;
                    end
                end
                SEQ_LEAD: begin
                    clock_line    = 1'b0;
                    start_line    = 1'b1;
                    phase         = SEQ_PRE;
                    clocks_left   = PRE_CLOCKS;
                    low_half_next = 1'b0;
                end
                default: begin
                    if (!low_half_next) begin
                        clock_line = 1'b1;
                        if (phase == SEQ_READ) begin
                            exp_r.flags.pixel_valid = 1'b1;
                            exp_r.pixel_value       = smp;
                            exp_r.flags.pixel_last  = (channel == NUM_CH - 1);
                            if (exp_r.flags.pixel_last)
                                captures++;
                        end
                        low_half_next = 1'b1;
                    end else begin
                        clock_line    = 1'b0;
                        low_half_next = 1'b0;
                        clock_finished();
                    end
                end
            endcase
            exp_r.flags.clock_level = clock_line;
            exp_r.flags.start_level = start_line;
            expected_q.push_back(exp_r);
        endfunction

        task report(input string msg);
            $display("mismatch at result %0d: %s", checked, msg);
            mismatches++;
        endtask

        task compare_field(input string name, input logic [SMP_W-1:0] got,
                           input logic [SMP_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_result(input logic clk_lvl, input logic start_lvl, input logic pix_valid,
                          input logic [SMP_W-1:0] pix_value, input logic pix_last,
                          input logic busy_lvl);
            readout_result_t want;
            if (expected_q.size() == 0) begin
                report("result with no request pending");
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("clock_level", SMP_W'(clk_lvl), SMP_W'(want.flags.clock_level));
            compare_field("start_level", SMP_W'(start_lvl), SMP_W'(want.flags.start_level));
            compare_field("pixel_valid", SMP_W'(pix_valid), SMP_W'(want.flags.pixel_valid));
            compare_field("pixel_value", pix_value, want.pixel_value);
            compare_field("pixel_last", SMP_W'(pix_last), SMP_W'(want.flags.pixel_last));
            compare_field("busy_res", SMP_W'(busy_lvl), SMP_W'(want.flags.busy));
        endtask

    endclass

endpackage

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Runs the readout sequencer through full line captures under several
// integration settings, with random request gaps and result stalls, and
// checks every half-period result against a cycle-true prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lsrs_pkg::*;
    import readout_check_pkg::*;

    localparam int LIMIT_CYCLES = 500_000;
    localparam int TOTAL_ITEMS  = 1400;
    localparam int QUIET_FROM   = TOTAL_ITEMS - 400;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  i_start_request = 1'b0;
    logic [SMP_W-1:0]      i_video_sample  = '0;
    logic                  i_out_stall     = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_clock_level;
    logic                  o_start_level;
    logic                  o_pixel_valid;
    logic [SMP_W-1:0]      o_pixel_value;
    logic                  o_pixel_last;
    logic                  o_busy_res;

    readout_scoreboard sb = new();
    bit quiet_tail      = 1'b0;
    int requests_sent   = 0;
    int config_writes   = 0;
    int cycle_count     = 0;

    line_sensor_readout_sequencer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_request (i_start_request),
        .i_video_sample  (i_video_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_clock_level   (o_clock_level),
        .o_start_level   (o_start_level),
        .o_pixel_valid   (o_pixel_valid),
        .o_pixel_value   (o_pixel_value),
        .o_pixel_last    (o_pixel_last),
        .o_busy_res      (o_busy_res)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // result stalls in random bursts
    always begin
        @(posedge i_clk);
        if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_clock_level, o_start_level, o_pixel_valid, o_pixel_value,
                            o_pixel_last, o_busy_res);
    end

    function automatic logic [SMP_W-1:0] pick_sample();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? '1 : '0;
        return SMP_W'($urandom);
    endfunction

    function automatic logic [SMP_W-1:0] pattern_sample(int k);
        case (k % 4)
            0: return '0;
            1: return '1;
            2: return {(SMP_W / 2){2'b10}};
            default: return {(SMP_W / 2){2'b01}};
        endcase
    endfunction

    // one request, with an optional gap before it
    task automatic drive_request(input logic req, input logic [SMP_W-1:0] smp);
        if (requests_sent >= QUIET_FROM)
            quiet_tail = 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_start_request <= req;
        i_video_sample  <= smp;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req, smp);
        requests_sent++;
    endtask

    // stop sending and let every result drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.apply_config(idx, data);
        i_cfg_we <= 1'b0;
        config_writes++;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] clocks,
                             input logic [CFG_DATA_W-1:0] corr);
        settle();
        write_config(CFG_IDX_INTEG_CLOCKS, clocks);
        write_config(CFG_IDX_INTEG_CORR, corr);
    endtask

    // random start noise while busy, ends as soon as the sequencer is idle
    task automatic finish_capture();
        while (!sb.idle())
            drive_request(1'($urandom_range(0, 1)), pick_sample());
    endtask

    initial begin
        int k;
        int n;
        logic [CFG_DATA_W-1:0] corr_v;
        logic [CFG_DATA_W-1:0] corr_eff;
        logic [CFG_DATA_W-1:0] clocks_v;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle requests with extreme samples
        for (k = 0; k < 4; k++)
            drive_request(1'b0, pattern_sample(k));

        // short length against the reset correction, start held high while busy
        settle();
        write_config(CFG_IDX_INTEG_CLOCKS, 24'd50);
        drive_request(1'b1, pattern_sample(1));
        k = 0;
        while (!sb.idle()) begin
            drive_request(1'b1, pattern_sample(k));
            k++;
        end

        // corner settings around the zero floor, spare indexes ignored
        while (requests_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 3))
                0: corr_v = '0;
                1: corr_v = 24'd255;
                2: corr_v = '1;
                default: corr_v = CFG_DATA_W'($urandom_range(0, 255));
            endcase
            corr_eff = CFG_DATA_W'(corr_v[CORR_W-1:0]);
            case ($urandom_range(0, 3))
                0: clocks_v = '0;
                1: clocks_v = corr_eff;
                2: clocks_v = corr_eff + CFG_DATA_W'($urandom_range(1, 3));
                default: clocks_v = CFG_DATA_W'($urandom_range(0, int'(corr_eff)));
            endcase
            configure(clocks_v, corr_v);
            write_config($urandom_range(0, 1) ? CFG_IDX_SPARE_2 : CFG_IDX_SPARE_3,
                         CFG_DATA_W'($urandom));
            n = $urandom_range(10, 40);
            repeat (n) drive_request(1'($urandom_range(0, 15) == 0), pick_sample());
            drive_request(1'b1, pick_sample());
            finish_capture();
        end

        quiet_tail = 1'b1;
        settle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests, %0d results checked, %0d full line captures",
                 requests_sent, sb.checked, sb.captures);
        $display("%0d register writes, integration from none up to a few clocks",
                 config_writes);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
